### sv/uart_drb_pkg.sv
// Shared types and constants for the UART dual ring buffer.
`default_nettype none

package uart_drb_pkg;

   localparam int RING_DEPTH = 256;
   localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam logic [7:0] CR_BYTE = 8'd13;
   localparam logic [7:0] LF_BYTE = 8'd10;

   typedef enum logic [1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_RECV = 2'd2,
      MODE_SEND = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_TX_FULL     = 2'd1,
      ST_RX_EMPTY    = 2'd2,
      ST_RX_OVERFLOW = 2'd3
   } status_type;

   typedef logic [PTR_W-1:0] ptr_type;

   // Advance a ring pointer, wrapping at the ring depth.
   function automatic ptr_type ring_next(input ptr_type p);
      ptr_type n;
      n = p + ptr_type'(1);
      if (p == ptr_type'(RING_DEPTH - 1)) begin
         n = '0;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### sv/uart_dual_ring_buffer_core.sv
// Top level: transmit and receive ring buffers between a CPU and a UART line.
// An accepted request word goes through the pending stage (registered ring memory read)
//   and then the response register; no new word is taken while one is pending.
// Reset (synchronous, active high) clears all ring pointers and both interrupt
//   enables, sets translate_ff to 1; the ring memories themselves are not cleared.
`default_nettype none

module uart_dual_ring_buffer_core
   import uart_drb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_data_in,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_out,
   output logic            rsp_data_valid,
   output logic [1:0]      rsp_status,
   output logic            rsp_tx_irq_enable,
   output logic            rsp_rx_irq_enable,
   // configuration
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);

   // Ring memories: one write and one registered read per cycle each.
   logic [7:0] tx_mem [RING_DEPTH];
   logic [7:0] rx_mem [RING_DEPTH];
   logic [7:0] tx_q_ff;
   logic [7:0] rx_q_ff;

   // Ring pointers and interrupt enables.
   ptr_type tx_wr_ff, tx_wr_in;
   ptr_type tx_rd_ff, tx_rd_in;
   ptr_type rx_wr_ff, rx_wr_in;
   ptr_type rx_rd_ff, rx_rd_in;
   logic    tx_en_ff, tx_en_in;
   logic    rx_en_ff, rx_en_in;
   logic    translate_ff;

   // Pending stage: a word whose memory read is in flight.
   logic       pend_ff;
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_rx_ff,    pend_rx_in;
   status_type pend_status_ff, pend_status_in;
   logic       pend_tx_en_ff;
   logic       pend_rx_en_ff;

   // Response register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_dvalid_ff;
   status_type rsp_status_ff;
   logic       rsp_tx_en_ff;
   logic       rsp_rx_en_ff;

   logic    accept;
   logic    tx_we, tx_re, rx_we, rx_re;
   ptr_type tx_wr_next, tx_rd_next, rx_wr_next, rx_rd_next;
   logic    tx_empty, tx_full, rx_empty, rx_full;
   logic [7:0] rx_byte;

   // Take a new word only when nothing is in flight and the response slot frees.
   assign req_ready = !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign tx_wr_next = ring_next(tx_wr_ff);
   assign tx_rd_next = ring_next(tx_rd_ff);
   assign rx_wr_next = ring_next(rx_wr_ff);
   assign rx_rd_next = ring_next(rx_rd_ff);

   assign tx_empty = (tx_wr_ff == tx_rd_ff);
   assign tx_full  = (tx_wr_next == tx_rd_ff);
   assign rx_empty = (rx_wr_ff == rx_rd_ff);
   assign rx_full  = (rx_wr_next == rx_rd_ff);

   // Decode the operation: pointer moves, memory strobes, flags and status.
   always_comb begin
      tx_wr_in       = tx_wr_ff;
      tx_rd_in       = tx_rd_ff;
      rx_wr_in       = rx_wr_ff;
      rx_rd_in       = rx_rd_ff;
      tx_en_in       = tx_en_ff;
      rx_en_in       = rx_en_ff;
      tx_we          = 1'b0;
      tx_re          = 1'b0;
      rx_we          = 1'b0;
      rx_re          = 1'b0;
      pend_valid_in  = 1'b0;
      pend_rx_in     = 1'b0;
      pend_status_in = ST_OK;
      unique case (mode_type'(req_mode))
         MODE_PUSH: begin
            // A push always arms the transmit interrupt, even when refused.
            if (tx_full) begin
               pend_status_in = ST_TX_FULL;
            end else begin
               tx_we    = 1'b1;
               tx_wr_in = tx_wr_next;
            end
            tx_en_in = 1'b1;
         end
         MODE_POP: begin
            if (rx_empty) begin
               pend_status_in = ST_RX_EMPTY;
               rx_en_in       = 1'b1;
            end else begin
               rx_re         = 1'b1;
               rx_rd_in      = rx_rd_next;
               pend_valid_in = 1'b1;
               pend_rx_in    = 1'b1;
            end
         end
         MODE_RECV: begin
            // Drop the byte on overflow and mask the receive interrupt.
            if (rx_full) begin
               pend_status_in = ST_RX_OVERFLOW;
               rx_en_in       = 1'b0;
            end else begin
               rx_we    = 1'b1;
               rx_wr_in = rx_wr_next;
            end
         end
         MODE_SEND: begin
            if (tx_empty) begin
               tx_en_in = 1'b0;
            end else begin
               tx_re         = 1'b1;
               tx_rd_in      = tx_rd_next;
               pend_valid_in = 1'b1;
               // Clear the transmit interrupt once the last byte leaves.
               if (tx_rd_next == tx_wr_ff) begin
                  tx_en_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Ring memories: write and registered read, both gated by acceptance.
   always_ff @(posedge clock) begin
      if (accept && tx_we) begin
         tx_mem[tx_wr_ff] <= req_data_in;
      end
      if (accept && tx_re) begin
         tx_q_ff <= tx_mem[tx_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rx_we) begin
         rx_mem[rx_wr_ff] <= req_data_in;
      end
      if (accept && rx_re) begin
         rx_q_ff <= rx_mem[rx_rd_ff];
      end
   end

   // Carriage return becomes line feed on a CPU pop when enabled.
   assign rx_byte = (translate_ff && rx_q_ff == CR_BYTE) ? LF_BYTE : rx_q_ff;

   // Control state: pointers, enables, configuration, stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wr_ff     <= '0;
         tx_rd_ff     <= '0;
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         tx_en_ff     <= 1'b0;
         rx_en_ff     <= 1'b0;
         translate_ff <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            translate_ff <= csr_wr_data;
         end
         if (accept) begin
            tx_wr_ff <= tx_wr_in;
            tx_rd_ff <= tx_rd_in;
            rx_wr_ff <= rx_wr_in;
            rx_rd_ff <= rx_rd_in;
            tx_en_ff <= tx_en_in;
            rx_en_ff <= rx_en_in;
         end
         pend_ff <= accept;
         // Pending word always finds the response slot free.
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of the pending stage and the response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_valid_ff  <= pend_valid_in;
         pend_rx_ff     <= pend_rx_in;
         pend_status_ff <= pend_status_in;
         pend_tx_en_ff  <= tx_en_in;
         pend_rx_en_ff  <= rx_en_in;
      end
      if (pend_ff) begin
         if (!pend_valid_ff) begin
            rsp_data_ff <= 8'd0;
         end else if (pend_rx_ff) begin
            rsp_data_ff <= rx_byte;
         end else begin
            rsp_data_ff <= tx_q_ff;
         end
         rsp_dvalid_ff <= pend_valid_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_tx_en_ff  <= pend_tx_en_ff;
         rsp_rx_en_ff  <= pend_rx_en_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_data_valid    = rsp_dvalid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_tx_irq_enable = rsp_tx_en_ff;
   assign rsp_rx_irq_enable = rsp_rx_en_ff;

endmodule

`default_nettype wire

### sv/uart_drb_checker.sv
// Port-level checker for the UART dual ring buffer, bound to the top level.
`default_nettype none

module uart_drb_checker
   import uart_drb_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_data_out,
   input wire logic       rsp_data_valid,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_tx_irq_enable,
   input wire logic       rsp_rx_irq_enable
);

   // Hold a stalled response word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // No byte carried means a zero byte.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |-> rsp_data_out == 8'd0)
      else $error("data_out nonzero without data_valid");

   // A refused push still arms the transmit interrupt.
   a_full_arms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_TX_FULL |-> rsp_tx_irq_enable && !rsp_data_valid)
      else $error("tx full without tx interrupt enable");

   // Overflow drops the byte and masks the receive interrupt.
   a_ovf_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RX_OVERFLOW |-> !rsp_rx_irq_enable && !rsp_data_valid)
      else $error("rx overflow left rx interrupt enabled");

   // An empty pop arms the receive interrupt and carries no byte.
   a_empty_arms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RX_EMPTY |-> rsp_rx_irq_enable && !rsp_data_valid)
      else $error("rx empty pop inconsistent");

endmodule

bind uart_dual_ring_buffer_core uart_drb_checker u_uart_drb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_data_out      (rsp_data_out),
   .rsp_data_valid    (rsp_data_valid),
   .rsp_status        (rsp_status),
   .rsp_tx_irq_enable (rsp_tx_irq_enable),
   .rsp_rx_irq_enable (rsp_rx_irq_enable)
);

`default_nettype wire
